// ----- rtl/amed_pkg.sv -----
// ----------------------------------------------------------------------------
// amed_pkg: shared types and constants
// widths, scaling constants and register indexes of the magnitude event
// detector
// ----------------------------------------------------------------------------
`default_nettype none

package amed_pkg;

	// field widths
	localparam int RAW_W    = 12;
	localparam int SCALED_W = 20;
	localparam int SQ_W     = 2 * SCALED_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int FRAC_W   = 16;
	localparam int RAD_W    = SUM_W + FRAC_W;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int MAG_W    = 19;
	localparam int IDX_W    = 13;
	localparam int TMR_W    = 28;
	localparam int TICK_W   = 29;
	localparam int SHIFT_W  = 3;

	// axis scaling: raw * 25600 + 57 is {raw * 100, 57}
	localparam int SCALE_MUL   = 100;
	localparam int SCALE_HI_W  = 19;
	localparam logic [7:0] SCALE_LO = 8'd57;
	localparam int SCALE_NUM_W = SCALE_HI_W + 8;
	localparam int DIV_XZ      = 114;
	localparam int DIV_Y       = 115;

	// magnitude: (r + 520) / 1040 taken as ((r + 520) >> 4) / 65
	localparam int MAG_BIAS    = 520;
	localparam int MAG_PRE_SH  = 4;
	localparam int MAG_DIV     = 65;
	localparam int MAG_NUM_W   = ROOT_W + 1 - MAG_PRE_SH;

	// reset values
	localparam logic [MAG_W-1:0]   AVG_RESET    = 19'd65536;
	localparam logic [MAG_W-1:0]   THR_RESET    = 19'd9830;
	localparam logic [TICK_W-1:0]  PERIOD_RESET = 29'd268435456;
	localparam logic [SHIFT_W-1:0] AVG_SH_RESET = 3'd3;
	localparam logic [SHIFT_W-1:0] DEV_SH_RESET = 3'd2;

	typedef enum logic [1:0] {
		REG_AVG_SHIFT,
		REG_DEV_SHIFT,
		REG_THRESHOLD,
		REG_PERIOD
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/amed_cdiv.sv -----
// ----------------------------------------------------------------------------
// amed_cdiv: bit-serial divider by a constant
// restoring division, one quotient bit per cycle, dividend shifted out at the
// top while quotient bits shift in at the bottom
// ----------------------------------------------------------------------------
`default_nettype none

module amed_cdiv
	import amed_pkg::*;
#(
	parameter int NUM_W   = 27,
	parameter int DIVISOR = 114
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	localparam int DEN_W = $clog2(DIVISOR + 1);
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [DEN_W:0] DEN = (DEN_W + 1)'(DIVISOR);

	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign ge    = (trial >= DEN);
	assign diff  = trial - DEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

`default_nettype wire

// ----- rtl/amed_isqrt.sv -----
// ----------------------------------------------------------------------------
// amed_isqrt: digit-serial integer square root
// two radicand bits in and one root bit out per cycle, floor result
// ----------------------------------------------------------------------------
`default_nettype none

module amed_isqrt
	import amed_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  rad,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 1;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [REM_W+1:0]  t;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;

	assign t     = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (t >= trial);
	assign diff  = t - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(ROOT_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- rtl/accel_magnitude_event_detector_unit.sv -----
// ----------------------------------------------------------------------------
// accel_magnitude_event_detector_unit: acceleration magnitude event detector
// scales three adc axes to millivolts, takes the vector magnitude in g, keeps
// a moving average and a deviation average, and flags deviation events
// ----------------------------------------------------------------------------
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: x_raw, y_raw, z_raw, timer_count
//                                    s_tuser: x_ok, y_ok, z_ok
// m_*       out  m_tvalid/m_tready   m_tdata: sample_index, magnitude,
//                                      moving_average, deviation, interval_ticks
//                                    m_tuser: event_res
// cfg_*     in   cfg_we              cfg_addr selects the register, cfg_data
//
// one sample is processed at a time: s_tready is high only while the sequencer
// is idle, so the next sample is not taken until the last result is loaded
// into the output register; between the input transfer and the result a sample
// passes the three bit-serial axis dividers, the shared squaring multiplier,
// the bit-serial square root, the /65 divider, the averages and the output
// register load
// arst_n returns the sequencer, the detector state and the config registers
// to their reset values
// a result waiting in the output register does not block the next input
// transfer; only a second finished result waits for m_tready
//
`default_nettype none

module accel_magnitude_event_detector_unit
	import amed_pkg::*;
#(
	parameter int SAMPLE_BUFFER_SIZE = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // x_raw, y_raw, z_raw, timer_count
	input  wire logic [2:0]   s_tuser,   // x_ok, y_ok, z_ok
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // sample_index, magnitude,
	                                     // moving_average, deviation,
	                                     // interval_ticks, zero fill
	output logic [0:0]        m_tuser,   // event_res
	// config write port
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [28:0]  cfg_data
);

	localparam logic [31:0] BUF_LIMIT = 32'(SAMPLE_BUFFER_SIZE);
	localparam int          OUT_W     = IDX_W + 3 * MAG_W + TICK_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_ROOT,
		ST_MAGDIV,
		ST_AVG,
		ST_DEV,
		ST_HOLD
	} state_t;

	state_t state_q;

	// config registers
	logic [SHIFT_W-1:0] avg_shift_q;
	logic [SHIFT_W-1:0] dev_shift_q;
	logic [MAG_W-1:0]   thr_q;
	logic [TICK_W-1:0]  period_q;

	// detector state
	logic [SCALED_W-1:0] last_x_q, last_y_q, last_z_q;
	logic [MAG_W-1:0]    avg_q;
	logic [MAG_W-1:0]    dev_q;
	logic [TMR_W-1:0]    prev_q;
	logic [IDX_W-1:0]    idx_q;

	// per-sample working registers
	logic [2:0]          ok_q;
	logic [TICK_W-1:0]   interval_q;
	logic [1:0]          sq_cnt_q;
	logic [SQ_W-1:0]     prod_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [MAG_W-1:0]    mag_q;

	// output register
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    out_q;
	logic                event_q;

	// input field split
	logic [RAW_W-1:0]    x_raw, y_raw, z_raw;
	logic [TMR_W-1:0]    timer_count;
	logic                accept;

	assign x_raw       = s_tdata[11:0];
	assign y_raw       = s_tdata[23:12];
	assign z_raw       = s_tdata[35:24];
	assign timer_count = s_tdata[63:36];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// index and interval for the incoming sample
	logic [IDX_W-1:0]  idx_next;
	logic [TICK_W-1:0] tick_diff;
	logic [TICK_W-1:0] interval_next;

	assign idx_next  = ({{(32 - IDX_W){1'b0}}, idx_q} > BUF_LIMIT) ? '0 : idx_q + 1'b1;
	assign tick_diff = TICK_W'(timer_count) - TICK_W'(prev_q);
	// counts not increasing means the timer wrapped once
	assign interval_next = (prev_q < timer_count) ? tick_diff : period_q + tick_diff;

	// axis scaling numerators, raw * 25600 + 57
	logic [SCALE_NUM_W-1:0] x_num, y_num, z_num;

	assign x_num = {SCALE_HI_W'(x_raw) * SCALE_HI_W'(SCALE_MUL), SCALE_LO};
	assign y_num = {SCALE_HI_W'(y_raw) * SCALE_HI_W'(SCALE_MUL), SCALE_LO};
	assign z_num = {SCALE_HI_W'(z_raw) * SCALE_HI_W'(SCALE_MUL), SCALE_LO};

	logic                   x_done, y_done, z_done;
	logic [SCALE_NUM_W-1:0] x_quot, y_quot, z_quot;

	amed_cdiv #(.NUM_W(SCALE_NUM_W), .DIVISOR(DIV_XZ)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(accept), .num(x_num),
		.done(x_done), .quot(x_quot)
	);

	amed_cdiv #(.NUM_W(SCALE_NUM_W), .DIVISOR(DIV_Y)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(accept), .num(y_num),
		.done(y_done), .quot(y_quot)
	);

	amed_cdiv #(.NUM_W(SCALE_NUM_W), .DIVISOR(DIV_XZ)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(accept), .num(z_num),
		.done(z_done), .quot(z_quot)
	);

	// sum of squares through one shared multiplier
	logic [SCALED_W-1:0] sq_in;
	logic [SUM_W-1:0]    sum_next;
	logic                root_start;

	always_comb begin
		case (sq_cnt_q)
			2'd0:    sq_in = last_x_q;
			2'd1:    sq_in = last_y_q;
			default: sq_in = last_z_q;
		endcase
	end

	assign sum_next   = sum_q + SUM_W'(prod_s1);
	assign root_start = (state_q == ST_SQUARE) && (sq_cnt_q == 2'd3);

	logic              root_done;
	logic [ROOT_W-1:0] root;

	amed_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start),
		.rad({sum_next, {FRAC_W{1'b0}}}),
		.done(root_done), .root(root)
	);

	// magnitude divider, rounding bias and /16 folded in ahead of /65
	logic [ROOT_W:0]      root_biased;
	logic [MAG_NUM_W-1:0] mag_num;
	logic                 md_done;
	logic [MAG_NUM_W-1:0] md_quot;
	logic [MAG_W-1:0]     mag_sat;

	assign root_biased = {1'b0, root} + (ROOT_W + 1)'(MAG_BIAS);
	assign mag_num     = root_biased[ROOT_W:MAG_PRE_SH];

	amed_cdiv #(.NUM_W(MAG_NUM_W), .DIVISOR(MAG_DIV)) u_div_mag (
		.clk(clk), .arst_n(arst_n), .start(root_done), .num(mag_num),
		.done(md_done), .quot(md_quot)
	);

	// saturate to the largest q3.16 value
	assign mag_sat = (|md_quot[MAG_NUM_W-1:MAG_W]) ? '1 : md_quot[MAG_W-1:0];

	// averages: (old * (2^k - 1) + new) >> k, as (old << k) - old + new
	localparam int EW_W = MAG_W + 8;

	logic [EW_W-1:0]  avg_acc, dev_acc;
	logic [EW_W-1:0]  avg_shr, dev_shr;
	logic [MAG_W-1:0] absd;

	assign avg_acc = (EW_W'(avg_q) << avg_shift_q) - EW_W'(avg_q) + EW_W'(mag_q);
	assign avg_shr = avg_acc >> avg_shift_q;
	assign absd    = (mag_q >= avg_q) ? mag_q - avg_q : avg_q - mag_q;
	assign dev_acc = (EW_W'(dev_q) << dev_shift_q) - EW_W'(dev_q) + EW_W'(absd);
	assign dev_shr = dev_acc >> dev_shift_q;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_x_q   <= '0;
			last_y_q   <= '0;
			last_z_q   <= '0;
			avg_q      <= AVG_RESET;
			dev_q      <= '0;
			prev_q     <= '0;
			idx_q      <= '0;
			sq_cnt_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result takes the output register as the old one leaves
			if ((state_q == ST_HOLD) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= idx_next;
						prev_q  <= timer_count;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					// all three dividers run in lock step
					if (x_done && y_done && z_done) begin
						if (ok_q[0]) last_x_q <= x_quot[SCALED_W-1:0];
						if (ok_q[1]) last_y_q <= y_quot[SCALED_W-1:0];
						if (ok_q[2]) last_z_q <= z_quot[SCALED_W-1:0];
						sq_cnt_q <= '0;
						state_q  <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_MAGDIV;
					end
				end
				ST_MAGDIV: begin
					if (md_done) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					avg_q   <= avg_shr[MAG_W-1:0];
					state_q <= ST_DEV;
				end
				ST_DEV: begin
					dev_q   <= dev_shr[MAG_W-1:0];
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q       <= s_tuser;
			interval_q <= interval_next;
		end
		if (state_q == ST_SCALE) begin
			sum_q <= '0;
		end else if (state_q == ST_SQUARE) begin
			if (sq_cnt_q != 2'd3) begin
				prod_s1 <= sq_in * sq_in;
			end
			if (sq_cnt_q != 2'd0) begin
				sum_q <= sum_next;
			end
		end
		if (md_done) begin
			mag_q <= mag_sat;
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_q   <= {interval_q, dev_q, avg_q, mag_q, idx_q};
			event_q <= (dev_q > thr_q);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_shift_q <= AVG_SH_RESET;
			dev_shift_q <= DEV_SH_RESET;
			thr_q       <= THR_RESET;
			period_q    <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_AVG_SHIFT: avg_shift_q <= cfg_data[SHIFT_W-1:0];
				REG_DEV_SHIFT: dev_shift_q <= cfg_data[SHIFT_W-1:0];
				REG_THRESHOLD: thr_q       <= cfg_data[MAG_W-1:0];
				REG_PERIOD:    period_q    <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(104 - OUT_W){1'b0}}, out_q};
	assign m_tuser  = event_q;

endmodule

`default_nettype wire
